[design/assert_macros.svh]
// Assertion macros for the design files; only the controller includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

[design/qcf_pkg.sv]
// Types and constants of the quadratic contour flattener.
package qcf_pkg;

  localparam int VERTEX_BITS   = 27;
  localparam int K_BITS        = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam logic [K_BITS-1:0] INTERVALS_RESET = 3'd5;
  localparam logic [0:0] REG_INTERVALS = 1'b0;

  typedef logic signed [VERTEX_BITS-1:0] vtx_t;

  typedef enum logic [1:0] {
    SEG_NONE  = 2'd0,
    SEG_LINE  = 2'd1,
    SEG_CURVE = 2'd2
  } seg_t;

  typedef enum logic [1:0] {
    SEL_START  = 2'd0,
    SEL_SAMPLE = 2'd1,
    SEL_END    = 2'd2
  } sel_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic emit;
    sel_t sel;
    logic curve;
    logic first;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    seg_t kind;
  } dp_stat_t;

endpackage

[design/qcf_dp.sv]
// Datapath: point history, segment endpoints, forward-difference sampler, vertex register.
module qcf_dp #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,
  input  logic                                 on_curve,
  input  logic                                 contour_start,
  input  logic [qcf_pkg::K_BITS-1:0]           kl,
  input  qcf_pkg::dp_cmd_t                     cmd,
  output qcf_pkg::dp_stat_t                    stat,
  output logic signed [qcf_pkg::VERTEX_BITS-1:0] vertex_x,
  output logic signed [qcf_pkg::VERTEX_BITS-1:0] vertex_y,
  output logic                                 is_curve,
  output logic                                 strip_first,
  output logic                                 last
);
  import qcf_pkg::*;

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [COORD_BITS:0]   half_t;

  crd_t prev_x, prev_y, older_x, older_y;
  logic prev_on, older_on;
  logic [1:0] points_seen;

  half_t s_x, s_y, q_x, q_y, e_x, e_y;
  vtx_t  v_x, v_y, d_x, d_y, a_x, a_y;

  logic [1:0] seen_eff;
  seg_t  kind;
  half_t s_x_new, s_y_new, e_x_new, e_y_new;
  vtx_t  sx_w, sy_w, qx_w, qy_w, ex_w, ey_w;
  vtx_t  dqx, dqy, ddx, ddy;
  logic [3:0] sh_d, sh_dd, sh_a;

  always_comb begin
    seen_eff = contour_start ? 2'd0 : points_seen;
    if (seen_eff != 2'd0 && prev_on && on_curve) begin
      kind = SEG_LINE;
    end else if (seen_eff == 2'd2 && !prev_on) begin
      kind = SEG_CURVE;
    end else begin
      kind = SEG_NONE;
    end
    if (kind == SEG_LINE || older_on) begin
      s_x_new = (kind == SEG_LINE) ? half_t'(prev_x) <<< 1 : half_t'(older_x) <<< 1;
      s_y_new = (kind == SEG_LINE) ? half_t'(prev_y) <<< 1 : half_t'(older_y) <<< 1;
    end else begin
      s_x_new = half_t'(older_x) + half_t'(prev_x);
      s_y_new = half_t'(older_y) + half_t'(prev_y);
    end
    if (on_curve) begin
      e_x_new = half_t'(point_x) <<< 1;
      e_y_new = half_t'(point_y) <<< 1;
    end else begin
      e_x_new = half_t'(prev_x) + half_t'(point_x);
      e_y_new = half_t'(prev_y) + half_t'(point_y);
    end
  end

  assign stat.kind = kind;

  always_comb begin
    sx_w  = vtx_t'(s_x);
    sy_w  = vtx_t'(s_y);
    qx_w  = vtx_t'(q_x);
    qy_w  = vtx_t'(q_y);
    ex_w  = vtx_t'(e_x);
    ey_w  = vtx_t'(e_y);
    dqx   = qx_w - sx_w;
    dqy   = qy_w - sy_w;
    ddx   = sx_w - (qx_w <<< 1) + ex_w;
    ddy   = sy_w - (qy_w <<< 1) + ey_w;
    sh_d  = 4'd11 - 4'(kl);
    sh_dd = 4'd10 - {kl, 1'b0};
    sh_a  = sh_dd + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_y      <= '0;
      prev_on     <= 1'b0;
      older_x     <= '0;
      older_y     <= '0;
      older_on    <= 1'b0;
      points_seen <= 2'd0;
    end else if (cmd.take) begin
      older_x     <= prev_x;
      older_y     <= prev_y;
      older_on    <= prev_on;
      prev_x      <= point_x;
      prev_y      <= point_y;
      prev_on     <= on_curve;
      points_seen <= (seen_eff == 2'd2) ? 2'd2 : seen_eff + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      s_x <= s_x_new;
      s_y <= s_y_new;
      q_x <= half_t'(prev_x) <<< 1;
      q_y <= half_t'(prev_y) <<< 1;
      e_x <= e_x_new;
      e_y <= e_y_new;
    end
    if (cmd.prep) begin
      v_x <= sx_w <<< 10;
      v_y <= sy_w <<< 10;
      d_x <= (dqx <<< sh_d) + (ddx <<< sh_dd);
      d_y <= (dqy <<< sh_d) + (ddy <<< sh_dd);
      a_x <= ddx <<< sh_a;
      a_y <= ddy <<< sh_a;
    end else if (cmd.emit && cmd.sel == SEL_SAMPLE) begin
      v_x <= v_x + d_x;
      v_y <= v_y + d_y;
      d_x <= d_x + a_x;
      d_y <= d_y + a_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        SEL_START: begin
          vertex_x <= sx_w <<< 10;
          vertex_y <= sy_w <<< 10;
        end
        SEL_SAMPLE: begin
          vertex_x <= v_x;
          vertex_y <= v_y;
        end
        SEL_END: begin
          vertex_x <= ex_w <<< 10;
          vertex_y <= ey_w <<< 10;
        end
        default: begin
          vertex_x <= '0;
          vertex_y <= '0;
        end
      endcase
      is_curve    <= cmd.curve;
      strip_first <= cmd.first;
      last        <= cmd.last;
    end
  end

endmodule

[design/qcf_ctrl.sv]
// Controller: input handshake, segment sequencing and output valid.
`include "assert_macros.svh"
module qcf_ctrl #(
  parameter int MAX_INTERVALS_LOG2 = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       point_valid,
  output logic                       point_stall,
  output logic                       vertex_valid,
  input  logic                       vertex_stall,
  input  logic [qcf_pkg::K_BITS-1:0] kl,
  input  qcf_pkg::dp_stat_t          stat,
  output qcf_pkg::dp_cmd_t           cmd
);
  import qcf_pkg::*;

  localparam int CNT_BITS = $clog2((1 << MAX_INTERVALS_LOG2) + 3);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next, last_idx;
  logic curve, curve_next;
  logic take, out_free, emit;

  assign point_stall = (state != ST_IDLE);
  assign take        = point_valid && (state == ST_IDLE);
  assign out_free    = !vertex_valid || !vertex_stall;
  assign emit        = (state == ST_EMIT) && out_free;
  assign last_idx    = curve ? CNT_BITS'((1 << kl) + 2) : CNT_BITS'(1);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    curve_next = curve;
    case (state)
      ST_IDLE: begin
        if (take && stat.kind != SEG_NONE) begin
          state_next = ST_SETUP;
          curve_next = (stat.kind == SEG_CURVE);
        end
      end
      ST_SETUP: begin
        state_next = ST_EMIT;
        cnt_next   = '0;
      end
      ST_EMIT: begin
        if (emit) begin
          if (cnt == last_idx) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.take  = take;
    cmd.prep  = (state == ST_SETUP);
    cmd.emit  = emit;
    cmd.curve = curve;
    cmd.first = (cnt == '0);
    cmd.last  = (cnt == last_idx);
    if (cnt == '0) begin
      cmd.sel = SEL_START;
    end else if (cnt == last_idx) begin
      cmd.sel = SEL_END;
    end else begin
      cmd.sel = SEL_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      curve        <= 1'b0;
      vertex_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      curve <= curve_next;
      if (emit) begin
        vertex_valid <= 1'b1;
      end else if (!vertex_stall) begin
        vertex_valid <= 1'b0;
      end
    end
  end

  `ASSERT_AT(a_emit_free, clk, rst, emit |-> (!vertex_valid || !vertex_stall))
  `ASSERT_AT(a_take_setup, clk, rst, (take && stat.kind != SEG_NONE) |=> state == ST_SETUP)
  `ASSERT_NEVER(a_cnt_range, clk, rst, state == ST_EMIT && cnt > last_idx)

endmodule

[design/quadratic_contour_flattener.sv]
// Top level of the quadratic contour flattener: register port, controller and datapath.
//
//   channel   direction  handshake                    payload
//   point     in         point_valid / point_stall    point_x, point_y, on_curve, contour_start
//   vertex    out        vertex_valid / vertex_stall  vertex_x, vertex_y, is_curve,
//                                                     strip_first, last
//   config    in         APB psel/penable/pwrite      paddr, pwdata, prdata
//
// An accepted point that completes no segment leaves the controller idle. After a setup
// state, a line gives two vertices and a curve 2^k + 3, one vertex per cycle while the
// vertex side does not stall, curve samples out of the forward-difference sampler.
// point_stall stays high from acceptance of a point that completes a segment until the last
// vertex is loaded into the output register; a stall on the vertex side holds the sampler.
// Reset is synchronous; it clears the point history and sets intervals_log2 to 5.
module quadratic_contour_flattener #(
  parameter int COORD_BITS         = 16,
  parameter int MAX_INTERVALS_LOG2 = 5
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     point_valid,
  output logic                                     point_stall,
  input  logic signed [COORD_BITS-1:0]             point_x,
  input  logic signed [COORD_BITS-1:0]             point_y,
  input  logic                                     on_curve,
  input  logic                                     contour_start,
  output logic                                     vertex_valid,
  input  logic                                     vertex_stall,
  output logic signed [qcf_pkg::VERTEX_BITS-1:0]   vertex_x,
  output logic signed [qcf_pkg::VERTEX_BITS-1:0]   vertex_y,
  output logic                                     is_curve,
  output logic                                     strip_first,
  output logic                                     last,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [qcf_pkg::CFG_ADDR_BITS-1:0]        paddr,
  input  logic [qcf_pkg::CFG_DATA_BITS-1:0]        pwdata,
  output logic [qcf_pkg::CFG_DATA_BITS-1:0]        prdata,
  output logic                                     pready
);
  import qcf_pkg::*;

  logic [K_BITS-1:0] intervals_log2, kl;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      intervals_log2 <= INTERVALS_RESET;
    end else if (psel && penable && pwrite && paddr[CFG_ADDR_BITS-1] == REG_INTERVALS) begin
      intervals_log2 <= pwdata[K_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[CFG_ADDR_BITS-1] == REG_INTERVALS) begin
      prdata = CFG_DATA_BITS'(intervals_log2);
    end else begin
      prdata = '0;
    end
  end

  assign kl = (intervals_log2 > K_BITS'(MAX_INTERVALS_LOG2)) ?
              K_BITS'(MAX_INTERVALS_LOG2) : intervals_log2;

  qcf_ctrl #(
    .MAX_INTERVALS_LOG2(MAX_INTERVALS_LOG2)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .vertex_valid(vertex_valid),
    .vertex_stall(vertex_stall),
    .kl          (kl),
    .stat        (stat),
    .cmd         (cmd)
  );

  qcf_dp #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .point_x      (point_x),
    .point_y      (point_y),
    .on_curve     (on_curve),
    .contour_start(contour_start),
    .kl           (kl),
    .cmd          (cmd),
    .stat         (stat),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .is_curve     (is_curve),
    .strip_first  (strip_first),
    .last         (last)
  );

endmodule

[sim/tb.sv]
// Testbench for the quadratic contour flattener: directed and random point streams.
`timescale 1ns / 100ps

module tb;
  import qcf_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int MAX_K = 5;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [CFG_ADDR_BITS-1:0] INTERVALS_ADDR = CFG_ADDR_BITS'(4 * REG_INTERVALS);

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic on_pt;
    logic starts;
  } point_t;

  typedef struct {
    vtx_t x;
    vtx_t y;
    logic curve;
    logic first;
    logic fin;
  } vertex_t;

  logic clk;
  logic rst;
  logic point_valid;
  logic point_stall;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic on_curve;
  logic contour_start;
  logic vertex_valid;
  logic vertex_stall = 1'b0;
  vtx_t vertex_x;
  vtx_t vertex_y;
  logic is_curve;
  logic strip_first;
  logic last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  vertex_t pending_vertices[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  longint prev_x, prev_y, older_x, older_y;
  bit prev_on, older_on;
  int held;
  logic [K_BITS-1:0] intervals;

  quadratic_contour_flattener #(
    .COORD_BITS(COORD_BITS),
    .MAX_INTERVALS_LOG2(MAX_K)
  ) dut (
    .clk(clk),
    .rst(rst),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point_x(point_x),
    .point_y(point_y),
    .on_curve(on_curve),
    .contour_start(contour_start),
    .vertex_valid(vertex_valid),
    .vertex_stall(vertex_stall),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .is_curve(is_curve),
    .strip_first(strip_first),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd12_000_000);
    $display("FAIL quadratic_contour_flattener");
    $finish;
  end

  always @(posedge clk) begin
    vertex_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    vertex_t want;
    if (!rst && vertex_valid && !vertex_stall) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex beat: x %0d, y %0d", vertex_x, vertex_y);
        fail_count++;
      end else begin
        want = pending_vertices.pop_front();
        check_field("vertex_x", want.x, vertex_x);
        check_field("vertex_y", want.y, vertex_y);
        check_field("is_curve", {63'd0, want.curve}, {63'd0, is_curve});
        check_field("strip_first", {63'd0, want.first}, {63'd0, strip_first});
        check_field("last", {63'd0, want.fin}, {63'd0, last});
      end
    end
  end

  function automatic void push_vertex(input longint x, input longint y, input logic curve,
                                      input logic first, input logic fin);
    vertex_t v;
    v.x = x[VERTEX_BITS-1:0];
    v.y = y[VERTEX_BITS-1:0];
    v.curve = curve;
    v.first = first;
    v.fin = fin;
    pending_vertices.insert(pending_vertices.size(), v);
  endfunction

  function automatic void reset_history();
    prev_x = 0;
    prev_y = 0;
    older_x = 0;
    older_y = 0;
    prev_on = 1'b0;
    older_on = 1'b0;
    held = 0;
    intervals = INTERVALS_RESET;
  endfunction

  function automatic void flatten_point(input point_t p);
    longint cx, cy, sx, sy, qx, qy, ex, ey, w0, w1, w2, steps, scale, i;
    int kk;
    cx = p.x;
    cy = p.y;
    if (p.starts) held = 0;
    if (held >= 1 && prev_on && p.on_pt) begin
      push_vertex(prev_x * 2048, prev_y * 2048, 1'b0, 1'b1, 1'b0);
      push_vertex(cx * 2048, cy * 2048, 1'b0, 1'b0, 1'b1);
    end else if (held >= 2 && !prev_on) begin
      sx = older_on ? 2 * older_x : older_x + prev_x;
      sy = older_on ? 2 * older_y : older_y + prev_y;
      qx = 2 * prev_x;
      qy = 2 * prev_y;
      ex = p.on_pt ? 2 * cx : prev_x + cx;
      ey = p.on_pt ? 2 * cy : prev_y + cy;
      kk = (intervals > MAX_K) ? MAX_K : int'(intervals);
      steps = longint'(1) << kk;
      scale = longint'(1024) >> (2 * kk);
      push_vertex(sx * 1024, sy * 1024, 1'b1, 1'b1, 1'b0);
      for (i = 0; i <= steps; i++) begin
        w0 = (steps - i) * (steps - i);
        w1 = 2 * i * (steps - i);
        w2 = i * i;
        push_vertex((w0 * sx + w1 * qx + w2 * ex) * scale,
                    (w0 * sy + w1 * qy + w2 * ey) * scale, 1'b1, 1'b0, 1'b0);
      end
      push_vertex(ex * 1024, ey * 1024, 1'b1, 1'b0, 1'b1);
    end
    older_x = prev_x;
    older_y = prev_y;
    older_on = prev_on;
    prev_x = cx;
    prev_y = cy;
    prev_on = p.on_pt;
    if (held < 2) held++;
  endfunction

  function automatic point_t pt(input int x, input int y, input logic on_pt,
                                input logic starts);
    point_t p;
    p.x = x[COORD_BITS-1:0];
    p.y = y[COORD_BITS-1:0];
    p.on_pt = on_pt;
    p.starts = starts;
    return p;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    logic signed [COORD_BITS-1:0] c;
    case ($urandom_range(3))
      0: c = COORD_BITS'($urandom);
      1: begin
        case ($urandom_range(3))
          0: c = 16'sh8000;
          1: c = 16'sh7fff;
          2: c = 16'sh0000;
          default: c = 16'shffff;
        endcase
      end
      2: c = COORD_BITS'($urandom_range(200) - 100);
      default: c = COORD_BITS'($urandom);
    endcase
    return c;
  endfunction

  task automatic send_point(input point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    point_x <= p.x;
    point_y <= p.y;
    on_curve <= p.on_pt;
    contour_start <= p.starts;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    flatten_point(p);
  endtask

  task automatic wait_drained();
    point_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_intervals(input logic [K_BITS-1:0] k);
    logic [CFG_DATA_BITS-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= INTERVALS_ADDR;
    pwdata <= CFG_DATA_BITS'(k);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    intervals = k;
    check_field("intervals_log2", {32'd0, CFG_DATA_BITS'(k)}, {32'd0, readback});
  endtask

  task automatic test_directed();
    send_point(pt(0, 0, 1, 0));
    send_point(pt(32767, 32767, 1, 0));
    send_point(pt(-32768, -32768, 1, 0));
    send_point(pt(-32768, 32767, 0, 0));
    send_point(pt(32767, -32768, 1, 0));
    send_point(pt(100, -100, 0, 0));
    send_point(pt(-1, -1, 0, 0));
    send_point(pt(32767, 32767, 0, 0));
    send_point(pt(-32768, -32768, 1, 0));
    wait_drained();
    send_point(pt(5, 5, 0, 1));
    send_point(pt(7, -9, 0, 0));
    send_point(pt(-3, 4, 1, 0));
    send_point(pt(1, 1, 1, 1));
    send_point(pt(2, 3, 1, 0));
    send_point(pt(-32768, 0, 0, 1));
    send_point(pt(0, 32767, 1, 0));
    send_point(pt(1, -1, 1, 0));
    send_point(pt(-1, 1, 1, 1));
    wait_drained();
  endtask

  task automatic test_interval_sweep();
    int k;
    for (k = 7; k >= 0; k--) begin
      set_intervals(K_BITS'(k));
      send_point(pt(-32768, 32767, 1, 1));
      send_point(pt(32767, 32767, 0, 0));
      send_point(pt(-32768, -32768, 0, 0));
      send_point(pt(32767, -32768, 1, 0));
      wait_drained();
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int k_max);
    int sent;
    int len;
    int j;
    point_t p;
    set_intervals(K_BITS'($urandom_range(k_max)));
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(2, 12);
      for (j = 0; j < len && sent < n_items; j++) begin
        if ($urandom_range(19) == 0) begin
          p.x = COORD_BITS'($urandom);
          p.y = COORD_BITS'($urandom);
          p.on_pt = 1'($urandom_range(1));
          p.starts = 1'($urandom_range(1));
        end else begin
          p.x = pick_coord();
          p.y = pick_coord();
          p.on_pt = ($urandom_range(9) < 6);
          p.starts = (j == 0);
        end
        if ($urandom_range(59) == 0) wait_drained();
        send_point(p);
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    point_valid <= 1'b0;
    point_x <= '0;
    point_y <= '0;
    on_curve <= 1'b0;
    contour_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    reset_history();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 31;
    recv_stall_pct = 53;
    test_directed();
    test_interval_sweep();
    test_random_traffic(110, 4);
    send_idle_pct = 53;
    recv_stall_pct = 31;
    test_random_traffic(110, 4);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(110, 7);
    wait_drained();
    if (fail_count == 0) begin
      $display("PASS quadratic_contour_flattener");
    end else begin
      $display("FAIL quadratic_contour_flattener");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/qcf_pkg.sv
design/qcf_dp.sv
design/qcf_ctrl.sv
design/quadratic_contour_flattener.sv
sim/tb.sv
